// ===== rtl/mau_pkg.sv =====
// ----------------------------------------------------------------------------
// mau_pkg
// Shared types and constants of the modular arithmetic unit.
// ----------------------------------------------------------------------------
package mau_pkg;

   localparam int unsigned WORD_BITS_DEF = 32;
   localparam logic [31:0] MODULUS_RESET = 32'hFFFF_FFFB;
   localparam int unsigned CMD_BITS = 3;
   localparam int unsigned QUEUE_DEPTH = 2;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_ADD = 3'd0,
      CMD_SUB = 3'd1,
      CMD_MUL = 3'd2,
      CMD_DIV = 3'd3,
      CMD_NEG = 3'd4,
      CMD_NOP = 3'd5
   } cmd_type;

endpackage

// ===== rtl/mau_front.sv =====
// ----------------------------------------------------------------------------
// mau_front
// Accepts commands, reduces both operands modulo m one bit per cycle and
// classifies unused commands.
// ----------------------------------------------------------------------------
module mau_front #(
   parameter int unsigned WORD_BITS = mau_pkg::WORD_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [WORD_BITS-1:0]     modulus,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [2:0]               in_cmd,
   input  logic [WORD_BITS-1:0]     in_a,
   input  logic [WORD_BITS-1:0]     in_b,
   output logic                     out_valid,
   input  logic                     out_ready,
   output mau_pkg::cmd_type         out_cmd,
   output logic [WORD_BITS-1:0]     out_a,
   output logic [WORD_BITS-1:0]     out_b
);
   import mau_pkg::*;

   localparam int unsigned CW = $clog2(WORD_BITS);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_RED  = 3'b010,
      F_DONE = 3'b100
   } fstate_type;

   fstate_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [WORD_BITS-1:0] sa_ff, sa_in, sb_ff, sb_in, ra_ff, ra_in, rb_ff, rb_in;
   cmd_type cmd_ff, cmd_in;
   logic [WORD_BITS:0] ta, tb;

   assign in_ready  = (state_ff == F_IDLE);
   assign out_valid = (state_ff == F_DONE);
   assign out_cmd   = cmd_ff;
   assign out_a     = ra_ff;
   assign out_b     = rb_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      sa_in = sa_ff;
      sb_in = sb_ff;
      ra_in = ra_ff;
      rb_in = rb_ff;
      cmd_in = cmd_ff;
      ta = {ra_ff, sa_ff[WORD_BITS-1]};
      tb = {rb_ff, sb_ff[WORD_BITS-1]};
      unique case (state_ff)
         F_IDLE: begin
            if (in_valid) begin
               sa_in = in_a;
               sb_in = in_b;
               ra_in = '0;
               rb_in = '0;
               cnt_in = '0;
               if (modulus < 2) cmd_in = CMD_NOP;
               else begin
                  case (in_cmd)
                     CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_NEG:
                        cmd_in = cmd_type'(in_cmd);
                     default: cmd_in = CMD_NOP;
                  endcase
               end
               state_in = F_RED;
            end
         end
         F_RED: begin
            ra_in = (ta >= {1'b0, modulus}) ? WORD_BITS'(ta - {1'b0, modulus})
                                             : WORD_BITS'(ta);
            rb_in = (tb >= {1'b0, modulus}) ? WORD_BITS'(tb - {1'b0, modulus})
                                             : WORD_BITS'(tb);
            sa_in = sa_ff << 1;
            sb_in = sb_ff << 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(WORD_BITS-1)) state_in = F_DONE;
         end
         F_DONE: if (out_ready) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= F_IDLE;
      else state_ff <= state_in;
      cnt_ff <= cnt_in;
      sa_ff <= sa_in;
      sb_ff <= sb_in;
      ra_ff <= ra_in;
      rb_ff <= rb_in;
      cmd_ff <= cmd_in;
   end

   a_red_below: assert property (@(posedge clock) disable iff (reset)
      out_valid && modulus >= 2 |-> out_a < modulus && out_b < modulus)
      else $error("operand not reduced");
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> !in_ready)
      else $error("front accepted twice");
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(out_a))
      else $error("front result dropped");

endmodule

// ===== rtl/mau_queue.sv =====
// ----------------------------------------------------------------------------
// mau_queue
// Short FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module mau_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = mau_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0] cnt_ff;
   logic push, pop;

   assign in_ready  = (cnt_ff != (AW+1)'(DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_data  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1;
         if (pop) rp_ff <= (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
      if (push) mem_ff[wp_ff] <= in_data;
   end
endmodule

// ===== rtl/mau_back.sv =====
// ----------------------------------------------------------------------------
// mau_back
// Executes one command: add/sub/neg in one step, multiply by shift-and-add,
// divide by extended Euclid with a restoring divider.
// ----------------------------------------------------------------------------
module mau_back #(
   parameter int unsigned WORD_BITS = mau_pkg::WORD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [WORD_BITS-1:0] modulus,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  mau_pkg::cmd_type     in_cmd,
   input  logic [WORD_BITS-1:0] in_a,
   input  logic [WORD_BITS-1:0] in_b,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [WORD_BITS-1:0] out_value,
   output logic                 out_fail
);
   import mau_pkg::*;

   localparam int unsigned CW = $clog2(WORD_BITS);
   localparam int unsigned W1 = WORD_BITS + 1;

   typedef enum logic [8:0] {
      B_IDLE  = 9'b000000001,
      B_DISP  = 9'b000000010,
      B_MUL   = 9'b000000100,
      B_DIVQ  = 9'b000001000,
      B_TUPD  = 9'b000010000,
      B_TADD  = 9'b000100000,
      B_CHK   = 9'b001000000,
      B_FINAL = 9'b010000000,
      B_OUT   = 9'b100000000
   } bstate_type;

   bstate_type state_ff, state_in;
   cmd_type cmd_ff, cmd_in;
   logic [WORD_BITS-1:0] a_ff, a_in, b_ff, b_in;
   logic [WORD_BITS-1:0] rc_ff, rc_in;
   logic [WORD_BITS-1:0] tp_ff, tp_in, tc_ff, tc_in;
   logic [WORD_BITS-1:0] q_ff, q_in, rem_ff, rem_in;
   logic [WORD_BITS-1:0] dsh_ff, dsh_in;
   logic [WORD_BITS-1:0] ma_ff, ma_in, mb_ff, mb_in, acc_ff, acc_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic odd_ff, odd_in, fail_ff, fail_in, phase_ff, phase_in;
   logic [WORD_BITS-1:0] res_ff, res_in;
   logic [W1-1:0] trem, dbl, sum1;
   logic [WORD_BITS-1:0] dbl_m, acc_m, addv, subv, u;
   logic div_last;

   assign in_ready  = (state_ff == B_IDLE);
   assign out_valid = (state_ff == B_OUT);
   assign out_value = res_ff;
   assign out_fail  = fail_ff;

   // modular doubling of acc and, when mb's top bit is set, add of ma
   assign dbl   = {acc_ff, 1'b0};
   assign dbl_m = (dbl >= {1'b0, modulus}) ? WORD_BITS'(dbl - {1'b0, modulus})
                                           : WORD_BITS'(dbl);
   assign sum1  = {1'b0, dbl_m} + {1'b0, ma_ff};
   assign acc_m = (mb_ff[WORD_BITS-1] &&
                   sum1 >= {1'b0, modulus}) ? WORD_BITS'(sum1 - {1'b0, modulus})
                : mb_ff[WORD_BITS-1] ? WORD_BITS'(sum1) : dbl_m;
   assign addv  = (a_ff >= modulus - b_ff) ? a_ff - (modulus - b_ff) : a_ff + b_ff;
   assign subv  = (a_ff < b_ff) ? a_ff + (modulus - b_ff) : a_ff - b_ff;
   assign trem  = {rem_ff, dsh_ff[WORD_BITS-1]};
   assign div_last = (cnt_ff == CW'(WORD_BITS-1));
   assign u = odd_ff ? tc_ff : ((tc_ff == '0) ? '0 : modulus - tc_ff);

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      a_in = a_ff; b_in = b_ff;
      rc_in = rc_ff; tp_in = tp_ff; tc_in = tc_ff;
      q_in = q_ff; rem_in = rem_ff; dsh_in = dsh_ff;
      ma_in = ma_ff; mb_in = mb_ff; acc_in = acc_ff;
      cnt_in = cnt_ff; odd_in = odd_ff; fail_in = fail_ff;
      phase_in = phase_ff; res_in = res_ff;
      unique case (state_ff)
         B_IDLE: if (in_valid) begin
            cmd_in = in_cmd; a_in = in_a; b_in = in_b;
            fail_in = 1'b0;
            state_in = B_DISP;
         end
         B_DISP: begin
            case (cmd_ff)
               CMD_ADD: begin res_in = addv; state_in = B_OUT; end
               CMD_SUB: begin res_in = subv; state_in = B_OUT; end
               CMD_NEG: begin
                  res_in = (a_ff == '0) ? '0 : modulus - a_ff;
                  state_in = B_OUT;
               end
               CMD_MUL: begin
                  ma_in = a_ff; mb_in = b_ff; acc_in = '0; cnt_in = '0;
                  phase_in = 1'b1;
                  state_in = B_MUL;
               end
               CMD_DIV: begin
                  if (b_ff == '0) begin
                     res_in = '0; fail_in = 1'b1; state_in = B_OUT;
                  end else begin
                     rc_in = b_ff;
                     tp_in = '0; tc_in = WORD_BITS'(1); odd_in = 1'b1;
                     dsh_in = modulus; rem_in = '0; q_in = '0; cnt_in = '0;
                     phase_in = 1'b0;
                     state_in = B_DIVQ;
                  end
               end
               default: begin res_in = '0; state_in = B_OUT; end
            endcase
         end
         B_MUL: begin
            acc_in = acc_m;
            mb_in = mb_ff << 1;
            cnt_in = cnt_ff + 1'b1;
            if (div_last) state_in = phase_ff ? B_FINAL : B_TADD;
         end
         B_DIVQ: begin
            // restoring divide: dsh / rc -> q, rem (phase 1: a / g)
            if (trem >= {1'b0, rc_ff}) begin
               rem_in = WORD_BITS'(trem - {1'b0, rc_ff});
               q_in = {q_ff[WORD_BITS-2:0], 1'b1};
            end else begin
               rem_in = WORD_BITS'(trem);
               q_in = {q_ff[WORD_BITS-2:0], 1'b0};
            end
            dsh_in = dsh_ff << 1;
            cnt_in = cnt_ff + 1'b1;
            if (div_last) state_in = phase_ff ? B_CHK : B_TUPD;
         end
         B_TUPD: begin
            if (rem_ff == '0) begin
               dsh_in = a_ff; rem_in = '0; q_in = '0; cnt_in = '0;
               phase_in = 1'b1;
               state_in = B_DIVQ;
            end else begin
               // q < m here since rem != 0 makes rc > 1 and dsh <= m; q mod m
               ma_in = (q_ff >= modulus) ? q_ff - modulus : q_ff;
               mb_in = tc_ff; acc_in = '0; cnt_in = '0;
               state_in = B_MUL;
            end
         end
         B_TADD: begin
            tp_in = tc_ff;
            tc_in = (tp_ff >= modulus - acc_ff) ? tp_ff - (modulus - acc_ff)
                                                : tp_ff + acc_ff;
            rc_in = rem_ff;
            odd_in = ~odd_ff;
            dsh_in = rc_ff; rem_in = '0; q_in = '0; cnt_in = '0;
            state_in = B_DIVQ;
         end
         B_CHK: begin
            if (rem_ff != '0) begin
               res_in = '0; fail_in = 1'b1; state_in = B_OUT;
            end else begin
               ma_in = u; mb_in = q_ff; acc_in = '0; cnt_in = '0;
               state_in = B_MUL;
            end
         end
         B_FINAL: begin res_in = acc_ff; state_in = B_OUT; end
         B_OUT: if (out_ready) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= B_IDLE;
      else state_ff <= state_in;
      cmd_ff <= cmd_in; a_ff <= a_in; b_ff <= b_in;
      rc_ff <= rc_in; tp_ff <= tp_in; tc_ff <= tc_in;
      q_ff <= q_in; rem_ff <= rem_in; dsh_ff <= dsh_in;
      ma_ff <= ma_in; mb_ff <= mb_in; acc_ff <= acc_in;
      cnt_ff <= cnt_in; odd_ff <= odd_in; fail_ff <= fail_in;
      phase_ff <= phase_in; res_ff <= res_in;
   end

   a_res_below: assert property (@(posedge clock) disable iff (reset)
      out_valid && modulus >= 2 |-> out_value < modulus)
      else $error("result not reduced");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_fail |-> out_value == '0)
      else $error("failed quotient carries value");
   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_DIVQ |-> rc_ff != '0)
      else $error("divide by zero in Euclid");
   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(out_value))
      else $error("result dropped");

endmodule

// ===== rtl/modular_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// modular_arithmetic_unit
// Modular add, subtract, multiply, negate and divide modulo a CSR modulus.
// ----------------------------------------------------------------------------
// Front: operand reduction; it takes no new request until its result is handed on.
// Back: add/sub/neg are computed at dispatch; multiply runs shift-and-add.
// Divide: after dispatch, each Euclid step with a nonzero remainder runs a divide
// and a multiply; then come the last Euclid divide, a/g and the final multiply.
// Reset is synchronous; the modulus resets to 4294967291, queue empties.
module modular_arithmetic_unit #(
   parameter int unsigned WORD_BITS = mau_pkg::WORD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // cmd[2:0], operand_a[34:3], operand_b[66:35]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // result_value[31:0], no_quotient[32]
);
   import mau_pkg::*;

   localparam int unsigned QW = CMD_BITS + 2 * WORD_BITS;

   logic [WORD_BITS-1:0] modulus_ff;
   logic f_valid, f_ready, b_valid, b_ready;
   cmd_type f_cmd;
   logic [WORD_BITS-1:0] f_a, f_b, val, a32, b32;
   logic [QW-1:0] q_out;
   logic fail;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) modulus_ff <= WORD_BITS'(MODULUS_RESET);
      else if (csr_valid) modulus_ff <= WORD_BITS'(csr_data);
   end

   assign a32 = WORD_BITS'(req_tdata[34:3]);
   assign b32 = WORD_BITS'(req_tdata[66:35]);

   mau_front #(.WORD_BITS(WORD_BITS)) u_front (
      .clock, .reset, .modulus(modulus_ff),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_cmd(req_tdata[2:0]), .in_a(a32), .in_b(b32),
      .out_valid(f_valid), .out_ready(f_ready),
      .out_cmd(f_cmd), .out_a(f_a), .out_b(f_b));

   mau_queue #(.WIDTH(QW)) u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_data({f_b, f_a, f_cmd}),
      .out_valid(b_valid), .out_ready(b_ready), .out_data(q_out));

   mau_back #(.WORD_BITS(WORD_BITS)) u_back (
      .clock, .reset, .modulus(modulus_ff),
      .in_valid(b_valid), .in_ready(b_ready),
      .in_cmd(cmd_type'(q_out[CMD_BITS-1:0])),
      .in_a(q_out[CMD_BITS +: WORD_BITS]),
      .in_b(q_out[CMD_BITS+WORD_BITS +: WORD_BITS]),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_value(val), .out_fail(fail));

   assign rsp_tdata = {7'd0, fail, 32'(val)};

endmodule
